[src/lpse_pkg.sv]
// Shared constants, codes and types of the LRAT proof stream encoder.
`timescale 1ns / 1ps
package lpse_pkg;

   localparam int ID_WIDTH   = 63;
   localparam int LIT_WIDTH  = 32;
   localparam int NUM_W      = (ID_WIDTH + 1 > LIT_WIDTH + 1) ? ID_WIDTH + 1 : LIT_WIDTH + 1;
   localparam int BCD_DIGITS = (NUM_W * 3 + 9) / 10 + 1;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int BIT_CNT_W  = $clog2(NUM_W + 1);
   localparam int DIG_CNT_W  = $clog2(BCD_DIGITS + 1);
   localparam int VAR_GROUP  = 7;

   localparam logic [2:0] MODE_BEGIN     = 3'd0;
   localparam logic [2:0] MODE_ADD       = 3'd1;
   localparam logic [2:0] MODE_LITERAL   = 3'd2;
   localparam logic [2:0] MODE_END_LITS  = 3'd3;
   localparam logic [2:0] MODE_CHAIN     = 3'd4;
   localparam logic [2:0] MODE_END_CHAIN = 3'd5;
   localparam logic [2:0] MODE_DELETE    = 3'd6;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_VAR  = 2'd1;
   localparam logic [1:0] KIND_DEC  = 2'd2;

   localparam logic [7:0] CHAR_A      = 8'h61;
   localparam logic [7:0] CHAR_D      = 8'h64;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_NL     = 8'h0a;
   localparam logic [7:0] CHAR_MINUS  = 8'h2d;
   localparam logic [7:0] BYTE_NUL    = 8'h00;
   localparam logic [7:0] VARINT_MORE = 8'h80;

   typedef struct packed {
      logic start;
      logic shift;
   } b2d_ctl_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic [3:0] top_digit;
   } b2d_stat_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } out_item_type;

   typedef struct packed {
      logic [2:0][7:0]   pre;
      logic [1:0]        pre_cnt;
      logic [1:0]        kind;
      logic [NUM_W-1:0]  num;
      logic [2:0][7:0]   post;
      logic [1:0]        post_cnt;
      logic              again;
      logic              emits;
   } plan_type;

endpackage

[src/lpse_b2d.sv]
// Iterative binary to BCD converter (shift and add-3), digits shifted out from the top.
`timescale 1ns / 1ps
module lpse_b2d import lpse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  b2d_ctl_type      ctl,
   input  logic [NUM_W-1:0] value,
   output b2d_stat_type     stat
);

   logic [NUM_W-1:0]     bin_ff;
   logic [BCD_W-1:0]     bcd_ff;
   logic [BIT_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic [BCD_W-1:0]     adj;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                   : bcd_ff[4*i +: 4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctl.start) begin
         bin_ff  <= value;
         bcd_ff  <= '0;
         cnt_ff  <= BIT_CNT_W'(NUM_W);
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         bcd_ff <= {adj[BCD_W-2:0], bin_ff[NUM_W-1]};
         bin_ff <= {bin_ff[NUM_W-2:0], 1'b0};
         cnt_ff <= cnt_ff - BIT_CNT_W'(1);
         if (cnt_ff == BIT_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end else if (ctl.shift) begin
         bcd_ff <= {bcd_ff[BCD_W-5:0], 4'h0};
      end
   end

   assign stat.busy      = busy_ff;
   assign stat.done      = busy_ff && (cnt_ff == BIT_CNT_W'(1));
   assign stat.top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

[src/lpse_out_reg.sv]
// Output register stage for the byte stream.
`timescale 1ns / 1ps
module lpse_out_reg import lpse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  out_item_type in_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_last
);

   logic         full_ff;
   out_item_type item_ff;

   assign in_ready = !full_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         full_ff <= 1'b1;
         item_ff <= in_item;
      end else if (rsp_ready) begin
         full_ff <= 1'b0;
      end
   end

   assign rsp_valid    = full_ff;
   assign rsp_out_byte = item_ff.out_byte;
   assign rsp_last     = item_ff.last;

endmodule

[src/lrat_proof_stream_encoder.sv]
// LRAT proof stream encoder top level: item sequencer, varint shifter, decimal digit emitter.
// Each accepted item is turned into its proof bytes, one byte per cycle at most, with rsp_last
// on the final byte; begin items and unused modes give no bytes. In binary format an item
// gives up to 12 bytes. In text format every decimal number runs through one shared
// shift-and-add-3 converter: a start step, a conversion step for each bit of the 64-bit number
// path, then a step that drops the leading zeros of the 21-digit result, the sending of the
// remaining digits, then the trailing bytes; a deletion that opens a line converts two numbers.
// Stalls on rsp_ready hold back the byte-sending steps. req_ready is high only between items;
// csr writes are always accepted.
`timescale 1ns / 1ps
module lrat_proof_stream_encoder import lpse_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_mode,
   input  logic [ID_WIDTH-1:0]  req_id,
   input  logic signed [31:0]   req_literal,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_binary_format
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRE   = 3'd1;
   localparam logic [2:0] ST_VAR   = 3'd2;
   localparam logic [2:0] ST_START = 3'd3;
   localparam logic [2:0] ST_CONV  = 3'd4;
   localparam logic [2:0] ST_SKIP  = 3'd5;
   localparam logic [2:0] ST_DIG   = 3'd6;
   localparam logic [2:0] ST_POST  = 3'd7;

   logic [2:0]           state_ff;
   logic                 binary_ff;
   logic                 run_ff;
   logic [ID_WIDTH-1:0]  latest_ff;
   logic [2:0][7:0]      pre_ff;
   logic [1:0]           pre_cnt_ff;
   logic [1:0]           kind_ff;
   logic [NUM_W-1:0]     num_ff;
   logic [ID_WIDTH-1:0]  num2_ff;
   logic [2:0][7:0]      post_ff;
   logic [1:0]           post_cnt_ff;
   logic                 again_ff;
   logic [DIG_CNT_W-1:0] dig_cnt_ff;

   plan_type             plan;
   logic                 accept;
   logic                 lneg;
   logic [31:0]          lmag;
   logic [NUM_W-1:0]     id_x2;
   logic                 emit_valid;
   logic                 emit_ready;
   logic                 emit_fire;
   out_item_type         emit_item;
   logic                 var_more;
   logic                 skip_zero;
   b2d_ctl_type          b2d_ctl;
   b2d_stat_type         b2d_stat;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   assign lneg  = req_literal[31];
   assign lmag  = lneg ? (~req_literal) + 32'd1 : req_literal;
   assign id_x2 = NUM_W'({req_id, 1'b0});

   always_comb begin
      plan          = '0;
      plan.kind     = KIND_NONE;
      plan.post     = {BYTE_NUL, BYTE_NUL, CHAR_SPACE};
      plan.post_cnt = 2'd1;
      unique case (req_mode)
         MODE_ADD: begin
            plan.emits = 1'b1;
            if (binary_ff) begin
               plan.kind = KIND_VAR;
               plan.num  = id_x2;
               if (run_ff) begin
                  plan.pre     = {BYTE_NUL, CHAR_A, BYTE_NUL};
                  plan.pre_cnt = 2'd2;
               end else begin
                  plan.pre     = {BYTE_NUL, BYTE_NUL, CHAR_A};
                  plan.pre_cnt = 2'd1;
               end
            end else begin
               plan.kind = KIND_DEC;
               plan.num  = NUM_W'(req_id);
               if (run_ff) begin
                  plan.pre     = {BYTE_NUL, CHAR_NL, CHAR_ZERO};
                  plan.pre_cnt = 2'd2;
               end
            end
         end
         MODE_LITERAL: begin
            plan.emits = 1'b1;
            if (binary_ff) begin
               plan.kind = KIND_VAR;
               plan.num  = NUM_W'({lmag, lneg});
            end else begin
               plan.kind = KIND_DEC;
               plan.num  = NUM_W'(lmag);
               if (lneg) begin
                  plan.pre     = {BYTE_NUL, BYTE_NUL, CHAR_MINUS};
                  plan.pre_cnt = 2'd1;
               end
            end
         end
         MODE_END_LITS, MODE_END_CHAIN: begin
            plan.emits = 1'b1;
            if (binary_ff) begin
               plan.pre     = {BYTE_NUL, BYTE_NUL, BYTE_NUL};
               plan.pre_cnt = 2'd1;
            end else begin
               plan.pre     = {BYTE_NUL, (req_mode == MODE_END_LITS) ? CHAR_SPACE : CHAR_NL,
                               CHAR_ZERO};
               plan.pre_cnt = 2'd2;
            end
         end
         MODE_CHAIN: begin
            plan.emits = 1'b1;
            plan.kind  = binary_ff ? KIND_VAR : KIND_DEC;
            plan.num   = binary_ff ? id_x2 : NUM_W'(req_id);
         end
         MODE_DELETE: begin
            plan.emits = 1'b1;
            if (binary_ff) begin
               plan.kind = KIND_VAR;
               plan.num  = id_x2;
               if (!run_ff) begin
                  plan.pre     = {BYTE_NUL, BYTE_NUL, CHAR_D};
                  plan.pre_cnt = 2'd1;
               end
            end else begin
               plan.kind = KIND_DEC;
               if (!run_ff) begin
                  plan.num      = NUM_W'(latest_ff);
                  plan.post     = {CHAR_SPACE, CHAR_D, CHAR_SPACE};
                  plan.post_cnt = 2'd3;
                  plan.again    = 1'b1;
               end else begin
                  plan.num = NUM_W'(req_id);
               end
            end
         end
         default: begin
            plan.emits = 1'b0;
         end
      endcase
   end

   assign var_more  = |num_ff[NUM_W-1:VAR_GROUP];
   assign skip_zero = (b2d_stat.top_digit == 4'h0) && (dig_cnt_ff > DIG_CNT_W'(1));

   always_comb begin
      emit_valid = 1'b0;
      emit_item  = '0;
      case (state_ff)
         ST_PRE: begin
            emit_valid         = 1'b1;
            emit_item.out_byte = pre_ff[0];
            emit_item.last     = (pre_cnt_ff == 2'd1) && (kind_ff == KIND_NONE);
         end
         ST_VAR: begin
            emit_valid         = 1'b1;
            emit_item.out_byte = (var_more ? VARINT_MORE : BYTE_NUL) |
                                 {1'b0, num_ff[VAR_GROUP-1:0]};
            emit_item.last     = !var_more;
         end
         ST_DIG: begin
            emit_valid         = 1'b1;
            emit_item.out_byte = CHAR_ZERO + {4'h0, b2d_stat.top_digit};
            emit_item.last     = 1'b0;
         end
         ST_POST: begin
            emit_valid         = 1'b1;
            emit_item.out_byte = post_ff[0];
            emit_item.last     = (post_cnt_ff == 2'd1) && !again_ff;
         end
         default: begin
            emit_valid = 1'b0;
         end
      endcase
   end

   assign emit_fire     = emit_valid && emit_ready;
   assign b2d_ctl.start = (state_ff == ST_START);
   assign b2d_ctl.shift = ((state_ff == ST_SKIP) && skip_zero) ||
                          ((state_ff == ST_DIG) && emit_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         binary_ff   <= 1'b1;
         run_ff      <= 1'b0;
         latest_ff   <= '0;
         pre_cnt_ff  <= '0;
         post_cnt_ff <= '0;
         kind_ff     <= KIND_NONE;
         again_ff    <= 1'b0;
         dig_cnt_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            binary_ff <= csr_binary_format;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_mode == MODE_BEGIN || req_mode == MODE_ADD) begin
                     latest_ff <= req_id;
                  end
                  if (req_mode == MODE_ADD) begin
                     run_ff <= 1'b0;
                  end
                  if (req_mode == MODE_DELETE) begin
                     run_ff <= 1'b1;
                  end
                  pre_ff      <= plan.pre;
                  pre_cnt_ff  <= plan.pre_cnt;
                  kind_ff     <= plan.kind;
                  num_ff      <= plan.num;
                  num2_ff     <= req_id;
                  post_ff     <= plan.post;
                  post_cnt_ff <= plan.post_cnt;
                  again_ff    <= plan.again;
                  if (plan.emits) begin
                     if (plan.pre_cnt != 2'd0) begin
                        state_ff <= ST_PRE;
                     end else if (plan.kind == KIND_VAR) begin
                        state_ff <= ST_VAR;
                     end else begin
                        state_ff <= ST_START;
                     end
                  end
               end
            end
            ST_PRE: begin
               if (emit_fire) begin
                  pre_ff     <= {BYTE_NUL, pre_ff[2], pre_ff[1]};
                  pre_cnt_ff <= pre_cnt_ff - 2'd1;
                  if (pre_cnt_ff == 2'd1) begin
                     unique case (kind_ff)
                        KIND_VAR: state_ff <= ST_VAR;
                        KIND_DEC: state_ff <= ST_START;
                        default:  state_ff <= ST_IDLE;
                     endcase
                  end
               end
            end
            ST_VAR: begin
               if (emit_fire) begin
                  num_ff <= num_ff >> VAR_GROUP;
                  if (!var_more) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_START: begin
               state_ff <= ST_CONV;
            end
            ST_CONV: begin
               if (b2d_stat.done) begin
                  state_ff   <= ST_SKIP;
                  dig_cnt_ff <= DIG_CNT_W'(BCD_DIGITS);
               end
            end
            ST_SKIP: begin
               if (skip_zero) begin
                  dig_cnt_ff <= dig_cnt_ff - DIG_CNT_W'(1);
               end else begin
                  state_ff <= ST_DIG;
               end
            end
            ST_DIG: begin
               if (emit_fire) begin
                  dig_cnt_ff <= dig_cnt_ff - DIG_CNT_W'(1);
                  if (dig_cnt_ff == DIG_CNT_W'(1)) begin
                     state_ff <= ST_POST;
                  end
               end
            end
            ST_POST: begin
               if (emit_fire) begin
                  post_ff     <= {BYTE_NUL, post_ff[2], post_ff[1]};
                  post_cnt_ff <= post_cnt_ff - 2'd1;
                  if (post_cnt_ff == 2'd1) begin
                     if (again_ff) begin
                        num_ff      <= NUM_W'(num2_ff);
                        post_ff     <= {BYTE_NUL, BYTE_NUL, CHAR_SPACE};
                        post_cnt_ff <= 2'd1;
                        again_ff    <= 1'b0;
                        state_ff    <= ST_START;
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   lpse_b2d u_b2d (
      .clock (clock),
      .reset (reset),
      .ctl   (b2d_ctl),
      .value (num_ff),
      .stat  (b2d_stat)
   );

   lpse_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (emit_valid),
      .in_ready     (emit_ready),
      .in_item      (emit_item),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   a_item_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode != MODE_BEGIN && req_mode <= MODE_DELETE) |=> state_ff != ST_IDLE)
      else $error("item with bytes did not start the sequencer");

   a_conv_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> b2d_stat.busy)
      else $error("waiting on an idle converter");

   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIG || state_ff == ST_SKIP) |-> dig_cnt_ff != '0)
      else $error("digit emission with no digits left");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && emit_item.last) |=> state_ff == ST_IDLE)
      else $error("last byte sent but item still in progress");

endmodule
